/* sv/ljsf_pkg.sv */
// Shared constants and widths for the shifted-force Lennard-Jones unit.
// No dependencies; imported by ljsf_div_pipe and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ljsf_pkg;

  // Number formats
  localparam int DIST_FRAC_BITS = 26;  // distance Q6.26
  localparam int D_W            = 32;  // distance width
  localparam int V_W            = 64;  // coefficient / result width

  // Power chain: pw[k] holds D^(k+1), k = 0..12
  localparam int PW_N  = 13;
  localparam int PW_W  = PW_N * D_W;   // width of D^13
  localparam int M6_W  = V_W + 6 * D_W; // |c6| * D^6

  // Division
  localparam int CLAMP_BIT = 81;                 // quotient magnitude clamp
  localparam int DIV_STEPS = CLAMP_BIT;          // one quotient bit per stage
  localparam int DIV_LAT   = DIV_STEPS + 2;      // entry + steps + final
  localparam int DEN_W     = PW_W;
  localparam int NUM_W     = M6_W + 3 + 7 * DIST_FRAC_BITS + 1;
  localparam int QUO_W     = CLAMP_BIT + 3;      // signed, holds +/- 2^81

  // Pipeline stage positions in the top level
  localparam int NUM_STG = PW_N;                 // numerator register
  localparam int Q_STG   = NUM_STG + DIV_LAT;    // quotient register
  localparam int SUM_W   = 100;                  // final sum width

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_C12    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C6     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FSHIFT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd4;

  localparam logic [V_W-1:0] MAX_POS = {1'b0, {(V_W-1){1'b1}}};
  localparam logic [V_W-1:0] MAX_NEG = {1'b1, {(V_W-1){1'b0}}};

  typedef struct packed {
    logic           ovf;
    logic [V_W-1:0] val;
  } sat_t;

endpackage

`default_nettype wire

/* sv/ljsf_div_pipe.sv */
// Pipelined restoring divider: floor(num/den) with sign, clamp at 2^81.
// Depends on ljsf_pkg. One request per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ljsf_div_pipe (
  input  wire logic                            clk_i,
  input  wire logic [ljsf_pkg::NUM_W-1:0]      num_i,
  input  wire logic [ljsf_pkg::DEN_W-1:0]      den_i,
  input  wire logic                            neg_i,
  output logic signed [ljsf_pkg::QUO_W-1:0]    quo_o
);
  import ljsf_pkg::*;

  logic [DEN_W-1:0]     rem_q [0:DIV_STEPS];
  logic [DEN_W-1:0]     den_q [0:DIV_STEPS];
  logic [CLAMP_BIT-1:0] low_q [0:DIV_STEPS];
  logic [CLAMP_BIT-1:0] quo_q [0:DIV_STEPS];
  logic                 big_q [0:DIV_STEPS];
  logic                 neg_q [0:DIV_STEPS];

  logic [NUM_W-CLAMP_BIT-1:0] hi;
  logic                       big_d;

  // Quotient reaches 2^81 iff the top part of num is not below den
  assign hi    = num_i[NUM_W-1:CLAMP_BIT];
  assign big_d = DEN_W'(hi) >= den_i;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= big_d ? '0 : DEN_W'(hi);
    den_q[0] <= den_i;
    low_q[0] <= num_i[CLAMP_BIT-1:0];
    quo_q[0] <= '0;
    big_q[0] <= big_d;
    neg_q[0] <= neg_i;
  end

  for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem_q[s-1], low_q[s-1][CLAMP_BIT-1]};
    assign ge    = trial >= {1'b0, den_q[s-1]};
    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? DEN_W'(trial - {1'b0, den_q[s-1]}) : DEN_W'(trial);
      den_q[s] <= den_q[s-1];
      low_q[s] <= {low_q[s-1][CLAMP_BIT-2:0], 1'b0};
      quo_q[s] <= {quo_q[s-1][CLAMP_BIT-2:0], ge};
      big_q[s] <= big_q[s-1];
      neg_q[s] <= neg_q[s-1];
    end
  end

  // Negative results round the magnitude up when a remainder is left
  logic [CLAMP_BIT:0]       mag;
  logic signed [QUO_W-1:0]  mag_s;
  always_comb begin
    if (big_q[DIV_STEPS]) begin
      mag = {1'b1, {CLAMP_BIT{1'b0}}};
    end else begin
      mag = {1'b0, quo_q[DIV_STEPS]}
          + (CLAMP_BIT+1)'(neg_q[DIV_STEPS] && (rem_q[DIV_STEPS] != '0));
    end
    mag_s = QUO_W'(mag);
  end

  always_ff @(posedge clk_i) begin
    quo_o <= neg_q[DIV_STEPS] ? -mag_s : mag_s;
  end

endmodule

`default_nettype wire

/* sv/lennard_jones_shifted_force_unit.sv */
// Top level of the shifted-force Lennard-Jones pair kernel (fixed point).
// Depends on ljsf_pkg and ljsf_div_pipe (two instances: energy, force).
//
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+------------------------------------
// request   | in        | start & !busy           | pair_distance_i (Q6.26)
// result    | out       | result_valid_o strobe   | pair_energy_o, pair_force_o,
//           |           |                         | overflow_flag_o
// config    | in        | cfg_valid_i & cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request per cycle; busy is never raised. A result passes, in order, through
// the D^k power chain and numerator registers, the one-bit-per-stage dividers
// and a final shift and saturation register. Results leave in request order.
// Reset (rst_ni low, async) clears the valid chain and all configuration
// registers to zero. The receiver cannot stall, so the pipeline advances
// every cycle.
`timescale 1ns / 1ps
`default_nettype none

module lennard_jones_shifted_force_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [ljsf_pkg::D_W-1:0]          pair_distance_i,
  // result
  output logic                                   result_valid_o,
  output logic signed [ljsf_pkg::V_W-1:0]        pair_energy_o,
  output logic signed [ljsf_pkg::V_W-1:0]        pair_force_o,
  output logic                                   overflow_flag_o,
  // configuration
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [ljsf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [ljsf_pkg::V_W-1:0]          cfg_data_i
);
  import ljsf_pkg::*;

  localparam int F = DIST_FRAC_BITS;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // Configuration. Coefficients are kept as sign + magnitude, ready for
  // the unsigned numerator math.
  // ---------------------------------------------------------------------
  logic [V_W-1:0]        c12_mag_q, c6_mag_q, fs_mag_q;
  logic                  c12_neg_q, c6_neg_q;
  logic signed [V_W-1:0] eshift_q, fshift_q;
  logic [D_W-1:0]        cutoff_q;
  logic [V_W-1:0]        cfg_mag;

  assign cfg_mag = cfg_data_i[V_W-1] ? (~cfg_data_i + V_W'(1)) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c12_mag_q <= '0;
      c12_neg_q <= 1'b0;
      c6_mag_q  <= '0;
      c6_neg_q  <= 1'b0;
      eshift_q  <= '0;
      fshift_q  <= '0;
      fs_mag_q  <= '0;
      cutoff_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_C12: begin
          c12_mag_q <= cfg_mag;
          c12_neg_q <= cfg_data_i[V_W-1];
        end
        REG_C6: begin
          c6_mag_q <= cfg_mag;
          c6_neg_q <= cfg_data_i[V_W-1];
        end
        REG_ESHIFT: eshift_q <= cfg_data_i;
        REG_FSHIFT: begin
          fshift_q <= cfg_data_i;
          fs_mag_q <= cfg_mag;
        end
        REG_CUTOFF: cutoff_q <= cfg_data_i[D_W-1:0];
        default: ;  // index beyond the map: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Valid and distance travel with every item
  // ---------------------------------------------------------------------
  logic           v_q [0:Q_STG];
  logic [D_W-1:0] d_q [0:Q_STG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Q_STG; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      v_q[0] <= start && !busy;
      for (int k = 1; k <= Q_STG; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0] <= pair_distance_i;
    for (int k = 1; k <= Q_STG; k++) begin
      d_q[k] <= d_q[k-1];
    end
  end

  // Row product a * b built from 32x32 limb products. Even and odd limb
  // products do not overlap, so one add joins them. Uses n limbs of a.
  function automatic logic [PW_W-1:0] row_mul(input logic [PW_W-1:0] a,
                                              input logic [D_W-1:0] b,
                                              input int n);
    logic [PW_W-1:0] ev, od;
    ev = '0;
    od = '0;
    for (int i = 0; i < n; i += 2) begin
      ev[D_W*i +: 2*D_W] = a[D_W*i +: D_W] * b;
    end
    for (int i = 1; i < n; i += 2) begin
      od[D_W*i +: 2*D_W] = a[D_W*i +: D_W] * b;
    end
    return ev + od;
  endfunction

  // ---------------------------------------------------------------------
  // Power chain: one 32-bit row multiply per stage, pw_q[k] = D^(k+1)
  // ---------------------------------------------------------------------
  logic [PW_W-1:0] pw_q [0:PW_N-1];

  always_ff @(posedge clk_i) begin
    pw_q[0] <= PW_W'(pair_distance_i);
  end

  for (genvar k = 1; k < PW_N; k++) begin : g_pow
    always_ff @(posedge clk_i) begin
      pw_q[k] <= row_mul(pw_q[k-1], d_q[k-1], k);
    end
  end

  // |c6| * D^6 as two row products (m6_lo_q, m6_hi_q) once D^6 is ready,
  // joined into m6_q[7], then carried to the numerator
  logic [M6_W-1:0]   m6_q [7:PW_N-1];
  logic [7*D_W-1:0]  m6_lo_q, m6_hi_q;
  logic [12*D_W-1:0] den12_q;

  always_ff @(posedge clk_i) begin
    m6_lo_q <= (7*D_W)'(row_mul(pw_q[5], c6_mag_q[D_W-1:0], 6));
    m6_hi_q <= (7*D_W)'(row_mul(pw_q[5], c6_mag_q[V_W-1:D_W], 6));
    m6_q[7] <= M6_W'(m6_lo_q) + (M6_W'(m6_hi_q) << D_W);
    for (int k = 8; k < PW_N; k++) begin
      m6_q[k] <= m6_q[k-1];
    end
    den12_q <= pw_q[11][12*D_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Numerators: a = k1*|c12|*2^(pF), b = k2*|c6|*D^6*2^((p-6)F), then
  // signed combine to magnitude + sign.
  // ---------------------------------------------------------------------
  function automatic logic [NUM_W:0] combine(input logic [NUM_W-1:0] a,
                                              input logic [NUM_W-1:0] b,
                                              input logic sa, input logic sb);
    logic ge;
    logic [NUM_W:0] res;
    ge = a >= b;
    if (sa == sb)  res = {sa, a + b};
    else if (ge)   res = {sa, a - b};
    else           res = {sb, b - a};
    return res;
  endfunction

  logic [NUM_W-1:0] ae, be, af, bf, c12w, m6w;
  logic [NUM_W:0]   ne, nf;

  always_comb begin
    c12w = NUM_W'(c12_mag_q);
    m6w  = NUM_W'(m6_q[PW_N-1]);
    ae   = c12w << (12 * F);
    be   = m6w << (6 * F);
    af   = ((c12w << 3) + (c12w << 2)) << (13 * F);  // 12 * |c12|
    bf   = ((m6w << 2) + (m6w << 1)) << (7 * F);     // 6 * |c6| * D^6
    ne   = combine(ae, be, c12_neg_q, c6_neg_q);
    nf   = combine(af, bf, c12_neg_q, c6_neg_q);
  end

  logic [NUM_W-1:0] ne_q, nf_q;
  logic             ne_neg_q, nf_neg_q;
  logic [DEN_W-1:0] de_q, df_q;

  always_ff @(posedge clk_i) begin
    ne_q     <= ne[NUM_W-1:0];
    ne_neg_q <= ne[NUM_W];
    nf_q     <= nf[NUM_W-1:0];
    nf_neg_q <= nf[NUM_W];
    de_q     <= DEN_W'(den12_q);
    df_q     <= pw_q[PW_N-1];
  end

  logic signed [QUO_W-1:0] qe, qf;

  ljsf_div_pipe u_div_energy (
    .clk_i (clk_i),
    .num_i (ne_q),
    .den_i (de_q),
    .neg_i (ne_neg_q),
    .quo_o (qe)
  );

  ljsf_div_pipe u_div_force (
    .clk_i (clk_i),
    .num_i (nf_q),
    .den_i (df_q),
    .neg_i (nf_neg_q),
    .quo_o (qf)
  );

  // ---------------------------------------------------------------------
  // Slope product |fshift| * |rc - r|, registered alongside the quotients
  // ---------------------------------------------------------------------
  logic [D_W-1:0]     dm;
  logic               dgt;
  logic [V_W+D_W-1:0] sp_prod_q;
  logic               sp_neg_q;

  assign dgt = d_q[Q_STG-1] > cutoff_q;
  assign dm  = dgt ? (d_q[Q_STG-1] - cutoff_q) : (cutoff_q - d_q[Q_STG-1]);

  always_ff @(posedge clk_i) begin
    sp_prod_q <= (V_W+D_W)'(row_mul(PW_W'(fs_mag_q), dm, 2));
    sp_neg_q  <= fshift_q[V_W-1] ^ dgt;
  end

  // ---------------------------------------------------------------------
  // Final sums and saturation
  // ---------------------------------------------------------------------
  function automatic sat_t saturate(input logic signed [SUM_W-1:0] x);
    sat_t r;
    if (x[SUM_W-1:V_W-1] == '0 || x[SUM_W-1:V_W-1] == '1) begin
      r.ovf = 1'b0;
      r.val = x[V_W-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = x[SUM_W-1] ? MAX_NEG : MAX_POS;
    end
    return r;
  endfunction

  logic signed [V_W+D_W:0]  sp_full;
  logic signed [SUM_W-1:0]  slope, e_sum, f_sum;
  sat_t                     e_sat, f_sat;
  logic                     d_zero;

  always_comb begin
    sp_full = sp_neg_q ? -$signed({1'b0, sp_prod_q}) : $signed({1'b0, sp_prod_q});
    slope   = SUM_W'(sp_full >>> F);  // floor toward minus infinity
    e_sum   = SUM_W'(qe) - SUM_W'(eshift_q) - slope;
    f_sum   = SUM_W'(qf) - SUM_W'(fshift_q);
    e_sat   = saturate(e_sum);
    f_sat   = saturate(f_sum);
    d_zero  = d_q[Q_STG] == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= v_q[Q_STG];
    end
  end

  always_ff @(posedge clk_i) begin
    pair_energy_o   <= d_zero ? MAX_POS : e_sat.val;
    pair_force_o    <= d_zero ? MAX_POS : f_sat.val;
    overflow_flag_o <= d_zero | e_sat.ovf | f_sat.ovf;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && pair_distance_i == '0) |-> ##(Q_STG + 2)
      (result_valid_o && overflow_flag_o && pair_energy_o == MAX_POS
       && pair_force_o == MAX_POS))
    else $error("zero distance did not give saturated result");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Q_STG + 2) result_valid_o)
    else $error("request lost in pipeline");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##(Q_STG + 2) !result_valid_o)
    else $error("result strobe without a request");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for lennard_jones_shifted_force_unit.
// Depends on ljsf_pkg and the unit's RTL. Predicts energy, force and overflow for
// each accepted request with wide exact arithmetic and checks results in order.
`timescale 1ns / 1ps

module testbench;
  import ljsf_pkg::*;

  localparam int DRAIN_CYCLES = 200;  // well past the pipeline depth

  typedef struct {
    logic [63:0] energy;
    logic [63:0] force_val;
    logic        ovf;
  } lj_result_t;

  // DUT ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [D_W-1:0]       pair_distance_i = '0;
  logic                 result_valid_o;
  logic signed [V_W-1:0] pair_energy_o;
  logic signed [V_W-1:0] pair_force_o;
  logic                 overflow_flag_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [V_W-1:0]       cfg_data_i = '0;

  // shadow copy of the configuration registers
  logic [63:0] c12_q, c6_q, eshift_q, fshift_q;
  logic [31:0] rc_q;

  lj_result_t pending_results[$];
  int         mismatches = 0;
  int         sent_count = 0;
  int         checked_count = 0;
  int         cfg_count = 0;
  bit         no_idle = 1'b0;

  lennard_jones_shifted_force_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .start(start), .busy(busy), .pair_distance_i(pair_distance_i),
    .result_valid_o(result_valid_o), .pair_energy_o(pair_energy_o),
    .pair_force_o(pair_force_o), .overflow_flag_o(overflow_flag_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------- prediction ----------------
  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? ~v + 64'd1 : v;
  endfunction

  function automatic logic [511:0] dist_pow(input logic [31:0] d, input int n);
    logic [511:0] acc;
    acc = 512'd1;
    for (int j = 0; j < n; j++) acc = acc * {480'd0, d};
    return acc;
  endfunction

  // floor((k1*c12*2^(p*F) + k2*c6*2^((p-6)*F)*d^6) / d^p), magnitude clamped to 2^81
  function automatic logic [127:0] inv_power_sum(input logic [31:0] d, input int p,
                                                 input logic [3:0] k1, input logic [3:0] k2);
    logic [511:0] a, b, m, den, q, r;
    logic [127:0] qq;
    logic         neg;
    a = {448'd0, abs64(c12_q)} * {508'd0, k1};
    a = a << (p * DIST_FRAC_BITS);
    b = {448'd0, abs64(c6_q)} * {508'd0, k2};
    b = (b << ((p - 6) * DIST_FRAC_BITS)) * dist_pow(d, 6);
    den = dist_pow(d, p);
    if (c12_q[63] == c6_q[63]) begin
      m = a + b; neg = c12_q[63];
    end else if (a >= b) begin
      m = a - b; neg = c12_q[63];
    end else begin
      m = b - a; neg = c6_q[63];
    end
    q = m / den;
    r = m % den;
    if (q >= (512'd1 << CLAMP_BIT)) begin
      qq = 128'd1 << CLAMP_BIT;
    end else begin
      qq = q[127:0];
      if (neg && r != 0) qq = qq + 128'd1;  // floor for negative fractions
    end
    return neg ? -qq : qq;
  endfunction

  // floor(fshift * (rc - d) / 2^F), rc < d allowed
  function automatic logic [127:0] slope_product(input logic [31:0] d);
    logic [127:0] prod;
    logic [31:0]  dm;
    logic         neg;
    neg = fshift_q[63];
    if (rc_q >= d) dm = rc_q - d;
    else begin
      dm = d - rc_q; neg = ~neg;
    end
    prod = {64'd0, abs64(fshift_q)} * {96'd0, dm};
    if (neg) prod = -prod;
    return $signed(prod) >>> DIST_FRAC_BITS;
  endfunction

  function automatic logic [63:0] clamp64(input logic [127:0] v, inout logic ovf);
    if (v[127:63] == {65{v[63]}}) return v[63:0];
    ovf = 1'b1;
    return v[127] ? MAX_NEG : MAX_POS;
  endfunction

  function automatic lj_result_t predict_pair(input logic [31:0] d);
    lj_result_t   res;
    logic [127:0] e, f;
    logic         ovf;
    ovf = 1'b0;
    if (d == 0) begin
      res.energy = MAX_POS; res.force_val = MAX_POS; res.ovf = 1'b1;
      return res;
    end
    e = inv_power_sum(d, 12, 4'd1, 4'd1) - {{64{eshift_q[63]}}, eshift_q} - slope_product(d);
    f = inv_power_sum(d, 13, 4'd12, 4'd6) - {{64{fshift_q[63]}}, fshift_q};
    res.energy    = clamp64(e, ovf);
    res.force_val = clamp64(f, ovf);
    res.ovf       = ovf;
    return res;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_distance(input logic [31:0] d);
    if (!no_idle) begin
      while ($urandom_range(99) < 18) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    pair_distance_i <= d;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(predict_pair(d));
    sent_count++;
  endtask

  // wait for the pipeline to empty, then settle
  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_C12:    c12_q    = val;
      REG_C6:     c6_q     = val;
      REG_ESHIFT: eshift_q = val;
      REG_FSHIFT: fshift_q = val;
      REG_CUTOFF: rc_q     = val[31:0];
      default: ;  // unmapped index, ignored
    endcase
    cfg_count++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [63:0] c12, input logic [63:0] c6,
                           input logic [63:0] es, input logic [63:0] fs,
                           input logic [31:0] rc);
    write_reg(REG_C12, c12);
    write_reg(REG_C6, c6);
    write_reg(REG_ESHIFT, es);
    write_reg(REG_FSHIFT, fs);
    write_reg(REG_CUTOFF, {32'd0, rc});
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  // random value with random magnitude range and sign
  function automatic logic [63:0] rand_coeff;
    logic [63:0] v;
    v = rand64() >> $urandom_range(63);
    return $urandom_range(1) ? -v : v;
  endfunction

  // mostly physical distances (0.5 .. 4.0), some tiny, huge, zero or any
  function automatic logic [31:0] rand_distance;
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(32'hFFFF, 1);
      2:       return $urandom_range(2) == 0 ? 32'd0 : 32'hFFFF_FFFF;
      default: return $urandom_range(32'h1000_0000, 32'h0200_0000);
    endcase
  endfunction

  // ---------------- checker ----------------
  always @(posedge clk_i) begin
    lj_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no request outstanding");
      end else begin
        exp_r = pending_results.pop_front();
        checked_count++;
        if (pair_energy_o !== exp_r.energy || pair_force_o !== exp_r.force_val ||
            overflow_flag_o !== exp_r.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: energy %h/%h force %h/%h ovf %b/%b (exp/act)",
                     exp_r.energy, pair_energy_o, exp_r.force_val, pair_force_o,
                     exp_r.ovf, overflow_flag_o);
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_values;
    // all coefficients zero: every nonzero distance yields zero
    send_distance(32'h0400_0000);
    send_distance(32'd0);
    send_distance(32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_directed;
    // argon-like values, r in Q6.26, rc = 2.5
    write_all(64'h0000_0004_0000_0000, -64'sh0000_0004_0000_0000,
              64'hFFFF_FFFF_F000_0000, 64'h0000_0000_1000_0000, 32'h0A00_0000);
    send_distance(32'd0);              // zero distance
    send_distance(32'd1);              // smallest, huge terms clamp
    send_distance(32'hFFFF_FFFF);      // largest, beyond cutoff
    send_distance(32'h0400_0000);      // 1.0
    send_distance(32'h047D_0000);      // near minimum
    send_distance(32'h0A00_0000);      // at cutoff
    send_distance(32'h0C00_0000);      // past cutoff, negative slope arm
    drain();
    // unmapped indexes are ignored
    write_reg(3'd5, rand64());
    write_reg(3'd7, rand64());
    send_distance(32'h0400_0000);
    drain();
    // extremes of every register
    write_all(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
              64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
    send_distance(32'h0400_0000);
    send_distance(32'hFFFF_FFFF);
    send_distance(32'd1);
    drain();
    write_all(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
              64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0);
    send_distance(32'h0400_0000);
    send_distance(32'hFFFF_FFFF);
    send_distance(32'h2000_0000);
    drain();
    // opposite-sign cancellation: c12 == -c6 gives zero energy at r = 1.0
    write_all(64'h0000_0001_0000_0000, 64'hFFFF_FFFF_0000_0000, 64'd0, 64'd0, 32'd0);
    send_distance(32'h0400_0000);
    send_distance(32'h0400_0001);
    send_distance(32'h03FF_FFFF);
    drain();
  endtask

  task automatic test_random_phases;
    for (int ph = 0; ph < 26; ph++) begin
      write_all(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(),
                $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h1000_0000, 32'h0400_0000));
      no_idle = (ph == 10);  // one long back-to-back stretch
      for (int i = 0; i < 50; i++) send_distance(rand_distance());
      drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    c12_q = '0; c6_q = '0; eshift_q = '0; fshift_q = '0; rc_q = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_random_phases();
    if (pending_results.size() != 0) mismatches++;
    $display("Covered %0d requests, %0d results checked, %0d register writes.",
             sent_count, checked_count, cfg_count);
    if (mismatches == 0) begin
      $display("lennard_jones_shifted_force_unit test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("lennard_jones_shifted_force_unit test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("lennard_jones_shifted_force_unit test failed");
    $finish;
  end

endmodule

/* files.f */
sv/ljsf_pkg.sv
sv/ljsf_div_pipe.sv
sv/lennard_jones_shifted_force_unit.sv
tb/testbench.sv
